>>> rtl/core/mqs_pkg.sv
// Shared types and constants for the marquee scroll sequencer.
// Used by every module in rtl/core; depends on nothing.
package mqs_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_HIDDEN_CHARS = 2'd0;
	localparam logic [1:0] CFG_CHAR_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_WAIT_BEFORE  = 2'd2;
	localparam logic [1:0] CFG_WAIT_AFTER   = 2'd3;

	// Reported phase codes
	localparam logic [2:0] PH_CODE_UNINIT      = 3'd0;
	localparam logic [2:0] PH_CODE_IDLE        = 3'd1;
	localparam logic [2:0] PH_CODE_INIT        = 3'd2;
	localparam logic [2:0] PH_CODE_WAIT_BEFORE = 3'd3;
	localparam logic [2:0] PH_CODE_ROLL        = 3'd4;
	localparam logic [2:0] PH_CODE_WAIT_AFTER  = 3'd5;

	// Input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Phase register, one-hot
	typedef enum logic [5:0] {
		PH_UNINIT      = 6'b000001,
		PH_IDLE        = 6'b000010,
		PH_INIT        = 6'b000100,
		PH_WAIT_BEFORE = 6'b001000,
		PH_ROLL        = 6'b010000,
		PH_WAIT_AFTER  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]  hidden_chars;
		logic [5:0]  char_width;
		logic [15:0] wait_before_ticks;
		logic [15:0] wait_after_ticks;
	} cfg_t;

	typedef struct packed {
		logic        redraw;
		logic [2:0]  phase_now;
		logic [7:0]  char_offset;
		logic [5:0]  pixels_left;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_UNINIT:      code = PH_CODE_UNINIT;
			PH_IDLE:        code = PH_CODE_IDLE;
			PH_INIT:        code = PH_CODE_INIT;
			PH_WAIT_BEFORE: code = PH_CODE_WAIT_BEFORE;
			PH_ROLL:        code = PH_CODE_ROLL;
			PH_WAIT_AFTER:  code = PH_CODE_WAIT_AFTER;
			default:        code = PH_CODE_UNINIT;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/core/mqs_cfg_regs.sv
// Configuration register file for the marquee scroll sequencer.
// Depends on mqs_pkg for register indexes and the config struct.
module mqs_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output mqs_pkg::cfg_t      cfg
);

	mqs_pkg::cfg_t cfg_q;

	// Always ready: every write is taken straight into its register
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hidden_chars      <= 8'd0;
			cfg_q.char_width        <= 6'd12;
			cfg_q.wait_before_ticks <= 16'd100;
			cfg_q.wait_after_ticks  <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mqs_pkg::CFG_HIDDEN_CHARS: cfg_q.hidden_chars      <= cfg_data[7:0];
				mqs_pkg::CFG_CHAR_WIDTH:   cfg_q.char_width        <= cfg_data[5:0];
				mqs_pkg::CFG_WAIT_BEFORE:  cfg_q.wait_before_ticks <= cfg_data;
				mqs_pkg::CFG_WAIT_AFTER:   cfg_q.wait_after_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/mqs_step.sv
// Phase and counter state of the marquee scroll sequencer with its
// combinational update per transfer. Depends on mqs_pkg.
module mqs_step #(
	parameter int CHAR_COUNT_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               opcode,
	input  logic               save_cpu,
	input  mqs_pkg::cfg_t      cfg,
	output mqs_pkg::res_t      res
);

	mqs_pkg::phase_t              phase_q, phase_d, phase_eff;
	logic [15:0]                  wait_q, wait_d;
	logic [5:0]                   pix_q, pix_d;
	logic [CHAR_COUNT_BITS-1:0]   chars_q, chars_d;
	logic [CHAR_COUNT_BITS-1:0]   offset_q, offset_d;
	logic [CHAR_COUNT_BITS-1:0]   hidden_c;
	logic [15:0]                  wait_before_c, wait_after_c;
	logic [5:0]                   width_c;
	logic                         run, redraw_d;

	// Clamp zero registers to one and fit the hidden count to the counter width
	assign hidden_c      = CHAR_COUNT_BITS'(cfg.hidden_chars);
	assign wait_before_c = (cfg.wait_before_ticks == 16'd0) ? 16'd1 : cfg.wait_before_ticks;
	assign wait_after_c  = (cfg.wait_after_ticks == 16'd0) ? 16'd1 : cfg.wait_after_ticks;
	assign width_c       = (cfg.char_width == 6'd0) ? 6'd1 : cfg.char_width;

	// Next state for one tick or start
	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		pix_d     = pix_q;
		chars_d   = chars_q;
		offset_d  = offset_q;
		redraw_d  = 1'b0;
		phase_eff = phase_q;
		run       = 1'b1;

		// Start forces init without running it; saving restarts init, roll and wait-after and freezes the other phases
		if (opcode == mqs_pkg::OP_START) begin
			phase_d = mqs_pkg::PH_INIT;
			run     = 1'b0;
		end else if (save_cpu) begin
			if (phase_q == mqs_pkg::PH_INIT || phase_q == mqs_pkg::PH_ROLL ||
			    phase_q == mqs_pkg::PH_WAIT_AFTER) begin
				phase_eff = mqs_pkg::PH_INIT;
				phase_d   = mqs_pkg::PH_INIT;
			end else begin
				run = 1'b0;
			end
		end

		if (run) begin
			unique case (phase_eff)
				mqs_pkg::PH_INIT: begin
					offset_d = '0;
					pix_d    = 6'd0;
					chars_d  = hidden_c;
					phase_d  = (hidden_c == '0) ? mqs_pkg::PH_IDLE : mqs_pkg::PH_WAIT_BEFORE;
					wait_d   = wait_before_c;
					redraw_d = 1'b1;
				end
				mqs_pkg::PH_WAIT_BEFORE: begin
					if (wait_q <= 16'd1) begin
						wait_d   = 16'd0;
						phase_d  = mqs_pkg::PH_ROLL;
						offset_d = '0;
						redraw_d = 1'b1;
					end else begin
						wait_d = wait_q - 16'd1;
					end
				end
				mqs_pkg::PH_ROLL: begin
					// Shift one pixel; load the next glyph when the current one is done; with none left, go to wait-after
					if (chars_q != '0 || pix_q != 6'd0) begin
						if (pix_q == 6'd0) begin
							pix_d    = width_c - 6'd1;
							chars_d  = chars_q - 1'b1;
							offset_d = offset_q + 1'b1;
						end else begin
							pix_d = pix_q - 6'd1;
						end
					end else begin
						pix_d   = 6'd0;
						phase_d = mqs_pkg::PH_WAIT_AFTER;
						wait_d  = wait_after_c;
					end
					redraw_d = 1'b1;
				end
				mqs_pkg::PH_WAIT_AFTER: begin
					if (wait_q <= 16'd1) begin
						wait_d   = 16'd0;
						phase_d  = mqs_pkg::PH_INIT;
						redraw_d = 1'b1;
					end else begin
						wait_d = wait_q - 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold state between transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mqs_pkg::PH_UNINIT;
			wait_q   <= 16'd0;
			pix_q    <= 6'd0;
			chars_q  <= '0;
			offset_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			pix_q    <= pix_d;
			chars_q  <= chars_d;
			offset_q <= offset_d;
		end
	end

	assign res.redraw      = redraw_d;
	assign res.phase_now   = mqs_pkg::phase_code(phase_d);
	assign res.char_offset = 8'(offset_d);
	assign res.pixels_left = pix_d;

`ifndef SYNTHESIS
	a_wait_before_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mqs_pkg::PH_WAIT_BEFORE |-> wait_q != 16'd0)
		else $error("wait-before phase with empty wait counter");
	a_idle_no_chars: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mqs_pkg::PH_IDLE |-> chars_q == '0)
		else $error("idle phase with characters left to scroll");
`endif

endmodule

>>> rtl/core/mqs_out_buf.sv
// Output register with one skid entry for the sequencer results.
// Depends on mqs_pkg for the result struct.
module mqs_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mqs_pkg::res_t      push_res,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output mqs_pkg::res_t      out_res
);

	mqs_pkg::res_t out_q, skid_q;
	logic          out_valid_q, skid_valid_q;
	logic          out_fire;

	assign out_fire  = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Track occupancy of output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Move payloads: skid drains first, otherwise a new result fills a free slot
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> out_valid_q && !skid_valid_q)
		else $error("skid entry not moved to output after transfer");
`endif

endmodule

>>> rtl/core/text_marquee_scroll_sequencer_unit.sv
// Top level of the marquee scroll sequencer.
// Depends on mqs_pkg, mqs_cfg_regs, mqs_step and mqs_out_buf.

// Each accepted item (a tick or a start command) produces exactly one result,
// registered in the output register, or first in the skid entry while that one
// is held, and then offered on the output channel. The block takes one item per
// clock: the phase and counter update is combinational in mqs_step, and an
// output register plus one skid entry let the input keep moving while a result
// waits; in_stall rises only when both are occupied. Configuration writes are
// taken at any time (cfg_ready is always high) but should only be issued while
// no results are pending. CHAR_COUNT_BITS sets the width of the character
// counters; char_offset shows the low 8 bits of the offset counter.
module text_marquee_scroll_sequencer_unit #(
	parameter int CHAR_COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic        save_cpu,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        redraw,
	output logic [2:0]  phase_now,
	output logic [7:0]  char_offset,
	output logic [5:0]  pixels_left
);

	mqs_pkg::cfg_t cfg;
	mqs_pkg::res_t step_res, out_res;
	logic          buf_full, accept;

	// Accept whenever the skid entry is free
	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	mqs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mqs_step #(
		.CHAR_COUNT_BITS (CHAR_COUNT_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.save_cpu (save_cpu),
		.cfg      (cfg),
		.res      (step_res)
	);

	mqs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_res  (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign redraw      = out_res.redraw;
	assign phase_now   = out_res.phase_now;
	assign char_offset = out_res.char_offset;
	assign pixels_left = out_res.pixels_left;

endmodule

>>> bench/tb_text_marquee_scroll_sequencer_unit.sv
// Self-checking bench for text_marquee_scroll_sequencer_unit: a directed table, then random
// tick/start traffic under several register settings and idle mixes, scored against a predictor.
// Depends on mqs_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_text_marquee_scroll_sequencer_unit;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic          op;
		logic          sv;
		logic          has_want;
		mqs_pkg::res_t want;
		logic [15:0]   hid;
		logic [15:0]   cw;
		logic [15:0]   wb;
		logic [15:0]   wa;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = 1'b0;
	logic        save_cpu = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        redraw;
	logic [2:0]  phase_now;
	logic [7:0]  char_offset;
	logic [5:0]  pixels_left;

	// Predictor copy of the configuration
	logic [7:0]  cfg_hidden;
	logic [5:0]  cfg_cw;
	logic [15:0] cfg_wb;
	logic [15:0] cfg_wa;

	// Predictor copy of the sequencer state
	logic [2:0]  mq_phase;
	logic [15:0] mq_wait;
	logic [5:0]  mq_pix;
	logic [7:0]  mq_chars;
	logic [7:0]  mq_offset;

	mqs_pkg::res_t frame_q[$];
	row_t  table_rows[$];
	int    err_count = 0;
	int    items_sent = 0;
	int    frames_seen = 0;
	int    settings_done = 0;
	int    cycle_count = 0;
	int    snd_idle_pct = 0;
	int    rcv_stall_pct = 0;

	text_marquee_scroll_sequencer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.save_cpu    (save_cpu),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.redraw      (redraw),
		.phase_now   (phase_now),
		.char_offset (char_offset),
		.pixels_left (pixels_left)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d frames outstanding", $time, cycle_count,
				frame_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Advance the predicted sequencer by one transfer and report the frame it shows
	task automatic advance_marquee(input logic op, input logic sv, output mqs_pkg::res_t r);
		logic run;
		run = 1'b1;
		r.redraw = 1'b0;
		if (op == mqs_pkg::OP_START) begin
			mq_phase = mqs_pkg::PH_CODE_INIT;
			run = 1'b0;
		end else if (sv) begin
			if (mq_phase == mqs_pkg::PH_CODE_INIT || mq_phase == mqs_pkg::PH_CODE_ROLL ||
			    mq_phase == mqs_pkg::PH_CODE_WAIT_AFTER)
				mq_phase = mqs_pkg::PH_CODE_INIT;
			else
				run = 1'b0;
		end
		if (run) begin
			case (mq_phase)
				mqs_pkg::PH_CODE_INIT: begin
					mq_offset = '0;
					mq_pix = '0;
					mq_chars = cfg_hidden;
					mq_phase = (mq_chars == 0) ? mqs_pkg::PH_CODE_IDLE :
						mqs_pkg::PH_CODE_WAIT_BEFORE;
					mq_wait = (cfg_wb == 0) ? 16'd1 : cfg_wb;
					r.redraw = 1'b1;
				end
				mqs_pkg::PH_CODE_WAIT_BEFORE: begin
					if (mq_wait <= 1) begin
						mq_wait = '0;
						mq_phase = mqs_pkg::PH_CODE_ROLL;
						mq_offset = '0;
						r.redraw = 1'b1;
					end else begin
						mq_wait = mq_wait - 1'b1;
					end
				end
				mqs_pkg::PH_CODE_ROLL: begin
					if (mq_chars != 0 || mq_pix != 0) begin
						if (mq_pix == 0) begin
							mq_pix = (cfg_cw == 0) ? 6'd1 : cfg_cw;
							mq_chars = mq_chars - 1'b1;
							mq_offset = mq_offset + 1'b1;
						end
						mq_pix = mq_pix - 1'b1;
					end else begin
						mq_pix = '0;
						mq_phase = mqs_pkg::PH_CODE_WAIT_AFTER;
						mq_wait = (cfg_wa == 0) ? 16'd1 : cfg_wa;
					end
					r.redraw = 1'b1;
				end
				mqs_pkg::PH_CODE_WAIT_AFTER: begin
					if (mq_wait <= 1) begin
						mq_wait = '0;
						mq_phase = mqs_pkg::PH_CODE_INIT;
						r.redraw = 1'b1;
					end else begin
						mq_wait = mq_wait - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		r.phase_now = mq_phase;
		r.char_offset = mq_offset;
		r.pixels_left = mq_pix;
	endtask

	// Offer one item, hold it until the transfer, then queue its frame
	task automatic send_item(input logic op, input logic sv, input logic has_want,
		input mqs_pkg::res_t want);
		mqs_pkg::res_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		save_cpu <= sv;
		do @(posedge clk); while (in_stall);
		advance_marquee(op, sv, r);
		frame_q.push_back(has_want ? want : r);
		items_sent++;
	endtask

	// Let every pending frame drain, then write all four registers
	task automatic apply_setting(input logic [15:0] hid, input logic [15:0] cw,
		input logic [15:0] wb, input logic [15:0] wa);
		logic [15:0] vals[4];
		vals[mqs_pkg::CFG_HIDDEN_CHARS] = hid;
		vals[mqs_pkg::CFG_CHAR_WIDTH] = cw;
		vals[mqs_pkg::CFG_WAIT_BEFORE] = wb;
		vals[mqs_pkg::CFG_WAIT_AFTER] = wa;
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_hidden = hid[7:0];
		cfg_cw = cw[5:0];
		cfg_wb = wb;
		cfg_wa = wa;
		settings_done++;
	endtask

	function automatic void add_item(input logic op, input logic sv);
		row_t row;
		row = '{kind: ROW_ITEM, default: '0};
		row.op = op;
		row.sv = sv;
		table_rows.push_back(row);
	endfunction

	function automatic void add_checked(input logic op, input logic sv,
		input mqs_pkg::res_t want);
		row_t row;
		row = '{kind: ROW_ITEM, default: '0};
		row.op = op;
		row.sv = sv;
		row.has_want = 1'b1;
		row.want = want;
		table_rows.push_back(row);
	endfunction

	function automatic void add_setting(input logic [15:0] hid, input logic [15:0] cw,
		input logic [15:0] wb, input logic [15:0] wa);
		row_t row;
		row = '{kind: ROW_SETTING, default: '0};
		row.hid = hid;
		row.cw = cw;
		row.wb = wb;
		row.wa = wa;
		table_rows.push_back(row);
	endfunction

	// Score each result transfer and drive the receiver's stall
	always @(posedge clk) begin : watch_results
		mqs_pkg::res_t got;
		mqs_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.redraw = redraw;
			got.phase_now = phase_now;
			got.char_offset = char_offset;
			got.pixels_left = pixels_left;
			frames_seen++;
			if (frame_q.size() == 0) begin
				err_count++;
				$display("%0t unexpected frame: redraw %0b phase %0d offset %0d pixels %0d",
					$time, got.redraw, got.phase_now, got.char_offset, got.pixels_left);
			end else begin
				want = frame_q.pop_front();
				if (got !== want) begin
					err_count++;
					$display("%0t mismatch: expected redraw %0b phase %0d offset %0d pixels %0d",
						$time, want.redraw, want.phase_now, want.char_offset,
						want.pixels_left);
					$display("%0t           actual   redraw %0b phase %0d offset %0d pixels %0d",
						$time, got.redraw, got.phase_now, got.char_offset, got.pixels_left);
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < rcv_stall_pct);
	end

	initial begin : run_test
		int   seg_items;
		int   noise;
		int   pick;
		logic op;
		logic sv;
		logic [15:0] hid;
		logic [15:0] cw;
		logic [15:0] wb;
		logic [15:0] wa;
		mqs_pkg::res_t dummy;

		// Reset values of the predictor
		cfg_hidden = 8'd0;
		cfg_cw = 6'd12;
		cfg_wb = 16'd100;
		cfg_wa = 16'd100;
		mq_phase = mqs_pkg::PH_CODE_UNINIT;
		mq_wait = '0;
		mq_pix = '0;
		mq_chars = '0;
		mq_offset = '0;
		dummy = '0;

		// Out of reset: ticks and saving do nothing until a start
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b0, mqs_pkg::PH_CODE_UNINIT, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b1, '{1'b0, mqs_pkg::PH_CODE_UNINIT, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_START, 1'b1, '{1'b0, mqs_pkg::PH_CODE_INIT, 8'd0, 6'd0});
		// Nothing hidden: init falls to idle, saving leaves idle alone
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b1, mqs_pkg::PH_CODE_IDLE, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b1, '{1'b0, mqs_pkg::PH_CODE_IDLE, 8'd0, 6'd0});
		// One hidden char, zero width and zero waits count as one
		add_setting(16'd1, 16'd0, 16'd0, 16'd0);
		add_checked(mqs_pkg::OP_START, 1'b0, '{1'b0, mqs_pkg::PH_CODE_INIT, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0,
			'{1'b1, mqs_pkg::PH_CODE_WAIT_BEFORE, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b1,
			'{1'b0, mqs_pkg::PH_CODE_WAIT_BEFORE, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b1, mqs_pkg::PH_CODE_ROLL, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b1, mqs_pkg::PH_CODE_ROLL, 8'd1, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0,
			'{1'b1, mqs_pkg::PH_CODE_WAIT_AFTER, 8'd1, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b1, mqs_pkg::PH_CODE_INIT, 8'd1, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0,
			'{1'b1, mqs_pkg::PH_CODE_WAIT_BEFORE, 8'd0, 6'd0});
		add_checked(mqs_pkg::OP_TICK, 1'b0, '{1'b1, mqs_pkg::PH_CODE_ROLL, 8'd0, 6'd0});
		// Saving while rolling restarts and runs init in the same tick
		add_checked(mqs_pkg::OP_TICK, 1'b1,
			'{1'b1, mqs_pkg::PH_CODE_WAIT_BEFORE, 8'd0, 6'd0});
		// All registers at their top values
		add_setting(16'd255, 16'd63, 16'd65535, 16'd65535);
		add_item(mqs_pkg::OP_START, 1'b0);
		add_item(mqs_pkg::OP_TICK, 1'b1);
		add_item(mqs_pkg::OP_TICK, 1'b0);
		add_item(mqs_pkg::OP_TICK, 1'b1);
		// Widest nominal glyph
		add_setting(16'd2, 16'd32, 16'd1, 16'd1);
		add_item(mqs_pkg::OP_START, 1'b1);
		add_item(mqs_pkg::OP_TICK, 1'b0);
		add_item(mqs_pkg::OP_TICK, 1'b0);
		add_item(mqs_pkg::OP_TICK, 1'b0);
		add_item(mqs_pkg::OP_TICK, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (table_rows[i]) begin
			if (table_rows[i].kind == ROW_SETTING)
				apply_setting(table_rows[i].hid, table_rows[i].cw, table_rows[i].wb,
					table_rows[i].wa);
			else
				send_item(table_rows[i].op, table_rows[i].sv, table_rows[i].has_want,
					table_rows[i].want);
		end

		// Random segments: each opens with a start and is mostly plain ticks
		for (int seg = 0; seg < 8; seg++) begin
			hid = (seg == 2) ? 16'd255 : 16'($urandom_range(0, 5));
			cw = (seg == 2) ? 16'd1 : (seg == 3) ? 16'd0 : (seg == 6) ? 16'd63 :
				(seg == 1) ? 16'd32 : 16'($urandom_range(1, 4));
			wb = (seg == 4) ? 16'd65535 : 16'($urandom_range(0, 4));
			wa = (seg == 7) ? 16'd65535 : 16'($urandom_range(1, 4));
			apply_setting(hid, cw, wb, wa);
			case (seg % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 65; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 65; end
				default: begin snd_idle_pct = 38; rcv_stall_pct = 38; end
			endcase
			// The long roll segment runs clean so the offset reaches its top
			seg_items = (seg == 2) ? 300 : 105;
			noise = (seg == 2) ? 0 : 10;
			send_item(mqs_pkg::OP_START, 1'($urandom_range(1)), 1'b0, dummy);
			for (int k = 1; k < seg_items; k++) begin
				pick = $urandom_range(99);
				if (pick < noise / 3) begin
					op = mqs_pkg::OP_START;
					sv = 1'($urandom_range(1));
				end else if (pick < noise) begin
					op = mqs_pkg::OP_TICK;
					sv = 1'b1;
				end else begin
					op = mqs_pkg::OP_TICK;
					sv = 1'b0;
				end
				send_item(op, sv, 1'b0, dummy);
			end
		end

		// Drain and settle
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d ticks and starts across %0d register settings and four idle mixes;",
			items_sent, settings_done);
		$display("%0d frames compared, %0d errors.", frames_seen, err_count);
		if (err_count == 0 && frame_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> text_marquee_scroll_sequencer_unit.f
rtl/core/mqs_pkg.sv
rtl/core/mqs_cfg_regs.sv
rtl/core/mqs_step.sv
rtl/core/mqs_out_buf.sv
rtl/core/text_marquee_scroll_sequencer_unit.sv
bench/tb_text_marquee_scroll_sequencer_unit.sv
